// ===== rtl/crsp_pkg.sv =====
// ----------------------------------------------------------------------------
// crsp_pkg: shared types, constants and helper functions
// Field widths, register and status codes, and the tangent arithmetic used by
// the spline point core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package crsp_pkg;

   localparam int MAX_POINTS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int COORD_W    = 32;
   localparam int PARAM_T_W  = 20;
   localparam int INDEX_W    = 4;
   localparam int NUM_PTS_W  = 5;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 3;

   // Tangents stay within 32 bits of magnitude; curve values need a few guard bits.
   localparam int TAN_W = 34;
   localparam int VAL_W = 36;

   // floor(m / 3) == (m * THIRD_K) >> THIRD_S for every m below 2^33.
   localparam logic [32:0] THIRD_K = 33'h155555556;
   localparam int          THIRD_S = 34;

   localparam logic signed [VAL_W-1:0] SAT_HI = VAL_W'(2147483647);
   localparam logic signed [VAL_W-1:0] SAT_LO = -SAT_HI - VAL_W'(1);

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_POINTS  = 3'd0,
      CSR_START_VEL_X = 3'd1,
      CSR_START_VEL_Y = 3'd2,
      CSR_END_VEL_X   = 3'd3,
      CSR_END_VEL_Y   = 3'd4
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_CLAMPED    = 2'd1,
      STATUS_FEW_POINTS = 2'd2,
      STATUS_SATURATED  = 2'd3
   } status_type;

   typedef struct packed {
      logic eval;
      logic few;
      logic clamp;
   } ctrl_type;

   // Half the difference of the two neighbors, rounded to nearest with ties toward plus infinity.
   function automatic logic signed [TAN_W-1:0] tangent_mid(
      input logic signed [COORD_W-1:0] next_p,
      input logic signed [COORD_W-1:0] prev_p);
      logic signed [TAN_W-1:0] d;
      d = TAN_W'(next_p) - TAN_W'(prev_p) + TAN_W'(1);
      return d >>> 1;
   endfunction

   // One third, rounded to nearest, through a reciprocal multiply on the magnitude.
   function automatic logic signed [TAN_W-1:0] third_nearest(
      input logic signed [TAN_W-1:0] v);
      logic [TAN_W:0]          m;
      logic [TAN_W+33:0]       p;
      logic signed [TAN_W-1:0] q;
      m = (TAN_W+1)'(v < 0 ? -v : v) + (TAN_W+1)'(1);
      p = (TAN_W+34)'(m) * (TAN_W+34)'(THIRD_K);
      q = TAN_W'(p >> THIRD_S);
      return (v < 0) ? -q : q;
   endfunction

endpackage

// ===== rtl/crsp_if.sv =====
// ----------------------------------------------------------------------------
// crsp_if: request and response channels
// Valid/ready channels that carry spline requests and evaluated points.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface crsp_req_if;
   import crsp_pkg::*;
   logic                        valid;
   logic                        ready;
   logic                        operation;
   logic [INDEX_W-1:0]          point_index;
   logic signed [COORD_W-1:0]   point_x;
   logic signed [COORD_W-1:0]   point_y;
   logic [PARAM_T_W-1:0]        param_t;

   modport source (output valid, operation, point_index, point_x, point_y, param_t,
                   input ready);
   modport sink   (input valid, operation, point_index, point_x, point_y, param_t,
                   output ready);
endinterface

interface crsp_rsp_if;
   import crsp_pkg::*;
   logic                        valid;
   logic                        ready;
   logic signed [COORD_W-1:0]   result_x;
   logic signed [COORD_W-1:0]   result_y;
   logic [STATUS_W-1:0]         status;

   modport source (output valid, result_x, result_y, status, input ready);
   modport sink   (input valid, result_x, result_y, status, output ready);
endinterface

// ===== rtl/catmull_rom_spline_point_core.sv =====
// ----------------------------------------------------------------------------
// catmull_rom_spline_point_core: 2D Catmull-Rom spline point generator
// Throughput: one request per cycle while the response side takes results; the
// 12-stage pipeline with a valid bit per stage and a ready chain sets that figure,
// and any empty stage takes a request. Reset clears the configuration registers
// and the valid bits; the point table is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module catmull_rom_spline_point_core #(
   parameter int MAX_POINTS = crsp_pkg::MAX_POINTS_DEF,
   parameter int FRAC_BITS  = crsp_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   crsp_req_if.sink                          req_if,
   crsp_rsp_if.source                        rsp_if,
   input  logic                              csr_we,
   input  logic [crsp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [crsp_pkg::COORD_W-1:0]      csr_wdata
);
   import crsp_pkg::*;

   // Table address, point count and comparison widths all follow the parameters.
   localparam int AW = $clog2(MAX_POINTS);
   localparam int NW = $clog2(MAX_POINTS + 1);
   localparam int FW = FRAC_BITS + 1;
   localparam int CW = ((PARAM_T_W > NW + FRAC_BITS) ? PARAM_T_W : NW + FRAC_BITS) + 1;

   // Pipeline stages. Each lerp level takes a multiply stage and an add stage.
   localparam int S_IN    = 0;
   localparam int S_MEM   = 1;
   localparam int S_TAN   = 2;
   localparam int S_THIRD = 3;
   localparam int S_GUIDE = 4;
   localparam int S_L1M   = 5;
   localparam int S_L1A   = 6;
   localparam int S_L2M   = 7;
   localparam int S_L2A   = 8;
   localparam int S_L3M   = 9;
   localparam int S_L3A   = 10;
   localparam int S_OUT   = 11;
   localparam int NS      = 12;

   // ------------------------------------------------------------------
   // Configuration registers. Axis 0 is x, axis 1 is y.
   // ------------------------------------------------------------------
   logic [NUM_PTS_W-1:0]      num_points_ff;
   logic signed [COORD_W-1:0] start_vel_ff [2];
   logic signed [COORD_W-1:0] end_vel_ff [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         num_points_ff   <= '0;
         start_vel_ff[0] <= '0;
         start_vel_ff[1] <= '0;
         end_vel_ff[0]   <= '0;
         end_vel_ff[1]   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NUM_POINTS:  num_points_ff   <= csr_wdata[NUM_PTS_W-1:0];
            CSR_START_VEL_X: start_vel_ff[0] <= csr_wdata;
            CSR_START_VEL_Y: start_vel_ff[1] <= csr_wdata;
            CSR_END_VEL_X:   end_vel_ff[0]   <= csr_wdata;
            CSR_END_VEL_Y:   end_vel_ff[1]   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipeline flow control. A stage loads when it is empty or when the
   // stage after it moves on, so bubbles are squeezed out; a stall holds
   // in place each occupied stage with no empty stage after it.
   // ------------------------------------------------------------------
   logic [NS-1:0] vld_ff, adv;

   always_comb begin
      adv[NS-1] = !vld_ff[NS-1] || rsp_if.ready;
      for (int k = NS - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_if.valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   assign req_if.ready = adv[S_IN];

   // ------------------------------------------------------------------
   // Front end: clamp t to the last point and split it into a section
   // index and a fraction. The last section takes t at its very end, so
   // the fraction may reach exactly one.
   // ------------------------------------------------------------------
   logic [NW-1:0] n_pts, n_m1;
   logic [CW-1:0] t_ext, t_max, t_c, seg_raw, seg_c;
   logic          few_in, clamp_in, first_in, last_in;
   logic [FW-1:0] f_in;
   ctrl_type      ctrl_in;

   always_comb begin
      n_pts    = (int'(num_points_ff) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(num_points_ff);
      n_m1     = n_pts - NW'(1);
      few_in   = n_pts < NW'(2);
      t_ext    = CW'(req_if.param_t);
      t_max    = CW'(n_m1) << FRAC_BITS;
      clamp_in = t_ext > t_max;
      t_c      = clamp_in ? t_max : t_ext;
      seg_raw  = t_c >> FRAC_BITS;
      seg_c    = (seg_raw >= CW'(n_m1)) ? CW'(n_pts - NW'(2)) : seg_raw;
      f_in     = FW'(t_c - (seg_c << FRAC_BITS));
      first_in = seg_c == '0;
      last_in  = (seg_c + CW'(1)) == CW'(n_m1);
      ctrl_in.eval  = req_if.operation == OP_EVAL;
      ctrl_in.few   = few_in;
      ctrl_in.clamp = clamp_in;
   end

   // Control and fraction travel along with the data.
   ctrl_type      ctrl_ff [NS];
   logic [FW-1:0] f_ff [NS];

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         ctrl_ff[0] <= ctrl_in;
         f_ff[0]    <= f_in;
      end
      for (int k = 1; k < NS; k++) begin
         if (adv[k]) begin
            ctrl_ff[k] <= ctrl_ff[k-1];
            f_ff[k]    <= f_ff[k-1];
         end
      end
   end

   // Input stage payload.
   logic [AW-1:0]             seg_ff;
   logic                      first0_ff, last0_ff;
   logic [INDEX_W-1:0]        slot_ff;
   logic signed [COORD_W-1:0] px_ff, py_ff;

   always_ff @(posedge clock) begin
      if (adv[S_IN]) begin
         seg_ff    <= AW'(seg_c);
         first0_ff <= first_in;
         last0_ff  <= last_in;
         slot_ff   <= req_if.point_index;
         px_ff     <= req_if.point_x;
         py_ff     <= req_if.point_y;
      end
   end

   // ------------------------------------------------------------------
   // Point table. Two copies take the same writes so that the four
   // neighbors of a section are read in the same cycle. A load writes at the
   // same pipeline step where an evaluation reads, so a later request
   // always sees an earlier load.
   // ------------------------------------------------------------------
   logic                  mem_we;
   logic [AW-1:0]         lo_addr [2];
   logic [AW-1:0]         hi_addr [2];
   logic [2*COORD_W-1:0]  lo_data [2];
   logic [2*COORD_W-1:0]  hi_data [2];

   assign mem_we = adv[S_MEM] && vld_ff[S_IN] && !ctrl_ff[S_IN].eval
                   && (int'(slot_ff) < MAX_POINTS);
   assign lo_addr[0] = seg_ff - AW'(1);
   assign lo_addr[1] = seg_ff;
   assign hi_addr[0] = seg_ff + AW'(1);
   assign hi_addr[1] = seg_ff + AW'(2);

   crsp_point_mem #(.ADDR_W(AW), .DATA_W(2 * COORD_W)) u_mem_lo (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (AW'(slot_ff)),
      .wr_data ({px_ff, py_ff}),
      .rd_en   (adv[S_MEM]),
      .rd_addr (lo_addr),
      .rd_data (lo_data)
   );

   crsp_point_mem #(.ADDR_W(AW), .DATA_W(2 * COORD_W)) u_mem_hi (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (AW'(slot_ff)),
      .wr_data ({px_ff, py_ff}),
      .rd_en   (adv[S_MEM]),
      .rd_addr (hi_addr),
      .rd_data (hi_data)
   );

   logic first1_ff, last1_ff;

   always_ff @(posedge clock) begin
      if (adv[S_MEM]) begin
         first1_ff <= first0_ff;
         last1_ff  <= last0_ff;
      end
   end

   // ------------------------------------------------------------------
   // Per axis: tangents, thirds, Bezier guides and three lerp levels.
   // ------------------------------------------------------------------
   logic signed [VAL_W-1:0] curve [2];

   for (genvar ax = 0; ax < 2; ax++) begin : g_axis
      localparam int HI = (ax == 0) ? 2 * COORD_W - 1 : COORD_W - 1;

      logic signed [COORD_W-1:0] p_prev, p_0, p_1, p_next;
      logic signed [COORD_W-1:0] a2_ff, d2_ff, a3_ff, d3_ff;
      logic signed [TAN_W-1:0]   v0_ff, v1_ff, t0_ff, t1_ff;
      logic signed [VAL_W-1:0]   ga_ff, gb_ff, gc_ff, gd_ff;
      logic signed [VAL_W-1:0]   ab, bc, cd, abc, bcd;

      assign p_prev = lo_data[0][HI -: COORD_W];
      assign p_0    = lo_data[1][HI -: COORD_W];
      assign p_1    = hi_data[0][HI -: COORD_W];
      assign p_next = hi_data[1][HI -: COORD_W];

      // The end tangents come from registers; interior ones from the neighbors.
      always_ff @(posedge clock) begin
         if (adv[S_TAN]) begin
            a2_ff <= p_0;
            d2_ff <= p_1;
            v0_ff <= first1_ff ? TAN_W'(start_vel_ff[ax]) : tangent_mid(p_1, p_prev);
            v1_ff <= last1_ff ? TAN_W'(end_vel_ff[ax]) : tangent_mid(p_next, p_0);
         end
         if (adv[S_THIRD]) begin
            a3_ff <= a2_ff;
            d3_ff <= d2_ff;
            t0_ff <= third_nearest(v0_ff);
            t1_ff <= third_nearest(v1_ff);
         end
         if (adv[S_GUIDE]) begin
            ga_ff <= VAL_W'(a3_ff);
            gb_ff <= VAL_W'(a3_ff) + VAL_W'(t0_ff);
            gc_ff <= VAL_W'(d3_ff) - VAL_W'(t1_ff);
            gd_ff <= VAL_W'(d3_ff);
         end
      end

      // De Casteljau: three lerps, then two, then one.
      crsp_lerp #(.FRAC_BITS(FRAC_BITS)) u_ab (
         .clock(clock), .en_mul(adv[S_L1M]), .en_add(adv[S_L1A]),
         .a(ga_ff), .b(gb_ff), .f(f_ff[S_GUIDE]), .y(ab));
      crsp_lerp #(.FRAC_BITS(FRAC_BITS)) u_bc (
         .clock(clock), .en_mul(adv[S_L1M]), .en_add(adv[S_L1A]),
         .a(gb_ff), .b(gc_ff), .f(f_ff[S_GUIDE]), .y(bc));
      crsp_lerp #(.FRAC_BITS(FRAC_BITS)) u_cd (
         .clock(clock), .en_mul(adv[S_L1M]), .en_add(adv[S_L1A]),
         .a(gc_ff), .b(gd_ff), .f(f_ff[S_GUIDE]), .y(cd));
      crsp_lerp #(.FRAC_BITS(FRAC_BITS)) u_abc (
         .clock(clock), .en_mul(adv[S_L2M]), .en_add(adv[S_L2A]),
         .a(ab), .b(bc), .f(f_ff[S_L1A]), .y(abc));
      crsp_lerp #(.FRAC_BITS(FRAC_BITS)) u_bcd (
         .clock(clock), .en_mul(adv[S_L2M]), .en_add(adv[S_L2A]),
         .a(bc), .b(cd), .f(f_ff[S_L1A]), .y(bcd));
      crsp_lerp #(.FRAC_BITS(FRAC_BITS)) u_pt (
         .clock(clock), .en_mul(adv[S_L3M]), .en_add(adv[S_L3A]),
         .a(abc), .b(bcd), .f(f_ff[S_L2A]), .y(curve[ax]));
   end

   // ------------------------------------------------------------------
   // Output register: saturation and status. Saturation outranks the
   // clamp flag; loads and short tables give zero coordinates.
   // ------------------------------------------------------------------
   logic signed [COORD_W-1:0] rx_in, ry_in, rx_ff, ry_ff;
   logic [STATUS_W-1:0]       st_in, st_ff;
   logic                      sat_x, sat_y;
   ctrl_type                  ctrl_l;

   always_comb begin
      ctrl_l = ctrl_ff[S_L3A];
      sat_x  = (curve[0] > SAT_HI) || (curve[0] < SAT_LO);
      sat_y  = (curve[1] > SAT_HI) || (curve[1] < SAT_LO);
      rx_in  = (curve[0] > SAT_HI) ? COORD_W'(SAT_HI) :
               (curve[0] < SAT_LO) ? COORD_W'(SAT_LO) : COORD_W'(curve[0]);
      ry_in  = (curve[1] > SAT_HI) ? COORD_W'(SAT_HI) :
               (curve[1] < SAT_LO) ? COORD_W'(SAT_LO) : COORD_W'(curve[1]);
      if (sat_x || sat_y) begin
         st_in = STATUS_SATURATED;
      end else if (ctrl_l.clamp) begin
         st_in = STATUS_CLAMPED;
      end else begin
         st_in = STATUS_OK;
      end
      if (!ctrl_l.eval) begin
         rx_in = '0;
         ry_in = '0;
         st_in = STATUS_OK;
      end else if (ctrl_l.few) begin
         rx_in = '0;
         ry_in = '0;
         st_in = STATUS_FEW_POINTS;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[S_OUT]) begin
         rx_ff <= rx_in;
         ry_ff <= ry_in;
         st_ff <= st_in;
      end
   end

   assign rsp_if.valid    = vld_ff[S_OUT];
   assign rsp_if.result_x = rx_ff;
   assign rsp_if.result_y = ry_ff;
   assign rsp_if.status   = st_ff;
endmodule

// ===== rtl/crsp_point_mem.sv =====
// ----------------------------------------------------------------------------
// crsp_point_mem: control point table
// One write port and two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module crsp_point_mem #(
   parameter int ADDR_W = 4,
   parameter int DATA_W = 64
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr [2],
   output logic [DATA_W-1:0] rd_data [2]
);
   logic [DATA_W-1:0] mem [1 << ADDR_W];
   logic [DATA_W-1:0] rd_data_ff [2];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff[0] <= mem[rd_addr[0]];
         rd_data_ff[1] <= mem[rd_addr[1]];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/crsp_lerp.sv =====
// ----------------------------------------------------------------------------
// crsp_lerp: two-stage linear interpolation
// Multiplies the difference by the fraction, then rounds and adds the base.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module crsp_lerp #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                en_mul,
   input  logic                                en_add,
   input  logic signed [crsp_pkg::VAL_W-1:0]   a,
   input  logic signed [crsp_pkg::VAL_W-1:0]   b,
   input  logic [FRAC_BITS:0]                  f,
   output logic signed [crsp_pkg::VAL_W-1:0]   y
);
   import crsp_pkg::*;

   localparam int PW = VAL_W + FRAC_BITS + 3;
   localparam logic signed [PW-1:0] HALF = PW'(64'd1 << (FRAC_BITS - 1));

   logic signed [VAL_W:0]       diff;
   logic signed [FRAC_BITS+1:0] f_s;
   logic signed [PW-1:0]        prod_in, prod_ff, rnd;
   logic signed [VAL_W-1:0]     a_ff, y_ff, y_in;

   assign diff    = (VAL_W+1)'(b) - (VAL_W+1)'(a);
   assign f_s     = $signed({1'b0, f});
   assign prod_in = PW'(diff) * PW'(f_s);
   assign rnd     = prod_ff + HALF;
   assign y_in    = a_ff + VAL_W'(rnd >>> FRAC_BITS);

   always_ff @(posedge clock) begin
      if (en_mul) begin
         a_ff    <= a;
         prod_ff <= prod_in;
      end
      if (en_add) begin
         y_ff <= y_in;
      end
   end

   assign y = y_ff;
endmodule

// ===== rtl/crsp_checker.sv =====
// ----------------------------------------------------------------------------
// crsp_checker: port-level assertions for the spline point core
// Checks handshake behavior and result/status consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module crsp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [crsp_pkg::COORD_W-1:0] result_x,
   input logic signed [crsp_pkg::COORD_W-1:0] result_y,
   input logic [crsp_pkg::STATUS_W-1:0]     status
);
   import crsp_pkg::*;

   localparam logic signed [COORD_W-1:0] MAX_C = COORD_W'(2147483647);
   localparam logic signed [COORD_W-1:0] MIN_C = -MAX_C - COORD_W'(1);

   // A stalled response stays and holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_x) && $stable(result_y)
      && $stable(status))
      else $error("stalled response changed");

   // With the output empty every stage can move, so a request is always taken.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused while the pipeline drains");

   // A short point table gives a zero point.
   a_few_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == STATUS_FEW_POINTS |-> result_x == '0 && result_y == '0)
      else $error("short table response is not zero");

   // A saturated response has a coordinate at a rail.
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == STATUS_SATURATED |->
      result_x == MAX_C || result_x == MIN_C || result_y == MAX_C || result_y == MIN_C)
      else $error("saturated status without a clamped coordinate");
endmodule

bind catmull_rom_spline_point_core crsp_checker u_crsp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .result_x  (rsp_if.result_x),
   .result_y  (rsp_if.result_y),
   .status    (rsp_if.status)
);
